>>> rtl/core/mean_filter_3x3_zero_pad_macros.svh
// assertion macros for the 3x3 mean filter checker
`ifndef MEAN_FILTER_3X3_ZERO_PAD_MACROS_SVH
`define MEAN_FILTER_3X3_ZERO_PAD_MACROS_SVH

// plain property, checked at every rising edge outside reset
`define MFZ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// condition now, consequence in the next cycle
`define MFZ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  `MFZ_ASSERT(lbl, clk, rstn, (ante) |=> (cons), msg)

`endif

>>> rtl/core/mfz_pkg.sv
// shared types and constants of the 3x3 mean filter
`timescale 1ns / 1ps
package mfz_pkg;

  localparam int unsigned PIX_W          = 8;
  localparam int unsigned COLSUM_W       = 10;
  localparam int unsigned SUM_W          = 12;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 13;
  localparam int unsigned FRAME_WIDTH_W  = 11;
  localparam int unsigned FRAME_HEIGHT_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned MID_CNT_W = $clog2(MID_DEPTH + 1);
  localparam int unsigned RES_DEPTH = 6;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [PIX_W-1:0] pixel_in;
  } mfz_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;
    logic             last;
  } mfz_out_t;

  typedef struct packed {
    logic [COLSUM_W-1:0] colsum;
    logic                first;
    logic                last_col;
    logic                emit;
    logic                final_row;
  } mfz_col_t;

endpackage

>>> rtl/core/mfz_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module mfz_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/mfz_fifo.sv
// small register queue, up to two beats written and one read per cycle
`timescale 1ns / 1ps
module mfz_fifo import mfz_pkg::*; #(
  parameter type         T     = mfz_out_t,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push0_i,
  input  logic          push1_i,
  input  T              data0_i,
  input  T              data1_i,
  input  logic          pop_i,
  output T              data_o,
  output logic          empty_o,
  output logic [CW-1:0] count_o
);

  T              mem_q [DEPTH];
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d, wp1;
  logic [CW-1:0] count_q, count_d;
  logic          do_pop;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (32'(p) == DEPTH - 1) ? '0 : p + PW'(1);
  endfunction

  assign wp1     = ptr_inc(wp_q);
  assign empty_o = (count_q == '0);
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];
  assign count_o = count_q;

  always_comb begin
    count_d = count_q + CW'(push0_i) + CW'(push1_i) - CW'(do_pop);
    rp_d    = do_pop ? ptr_inc(rp_q) : rp_q;
    wp_d    = push1_i ? ptr_inc(wp1) : (push0_i ? wp1 : wp_q);
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wp_q] <= data0_i;
    end
    if (push1_i) begin
      mem_q[wp1] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      count_q <= count_d;
    end
  end

endmodule

>>> rtl/core/mfz_front.sv
// front end: frame registers, raster counters, line stores and column sums
`timescale 1ns / 1ps
module mfz_front import mfz_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  push_i,
  input  mfz_in_t               item_i,
  output logic                  full_o,
  input  logic [MID_CNT_W-1:0]  mid_count_i,
  output logic                  col_push_o,
  output mfz_col_t              col_o
);

  localparam int unsigned AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RAM_W = 2 * PIX_W;

  logic [WW-1:0] fw_q, fw_d;
  logic [HW-1:0] fh_q, fh_d;
  logic [AW-1:0] col_q, col_d, flush_q, flush_d;
  logic [RW-1:0] row_q, row_d;
  logic          pend_q, pend_d;

  logic [FRAME_WIDTH_W-1:0]  wval;
  logic [FRAME_HEIGHT_W-1:0] hval;
  logic width_hit, height_hit, restart;

  logic          accept, is_pix, is_flush, go, col_last;
  logic [AW-1:0] c;
  logic [RW-1:0] row_eff;

  logic             s1_valid_q, s1_wr_q, s1_first_q, s1_last_q, s1_emit_q, s1_final_q;
  logic             s1_top_ok_q, s1_mid_ok_q;
  logic [AW-1:0]    s1_addr_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic             fwd_hit_q, fwd_hit_d;
  logic [RAM_W-1:0] fwd_data_q;

  logic [RAM_W-1:0] rdata, wdata;
  logic [PIX_W-1:0] upper_eff, lower_eff, top, mid;

  // configuration
  assign wval       = cfg_wdata_i[FRAME_WIDTH_W-1:0];
  assign hval       = cfg_wdata_i[FRAME_HEIGHT_W-1:0];
  assign width_hit  = cfg_valid_i && (cfg_index_i == REG_FRAME_WIDTH);
  assign height_hit = cfg_valid_i && (cfg_index_i == REG_FRAME_HEIGHT);
  assign restart    = width_hit || height_hit;

  always_comb begin
    fw_d = fw_q;
    fh_d = fh_q;
    if (width_hit) begin
      if (wval == '0) begin
        fw_d = WW'(1);
      end else if (32'(wval) > MAX_WIDTH) begin
        fw_d = WW'(MAX_WIDTH);
      end else begin
        fw_d = WW'(wval);
      end
    end
    if (height_hit) begin
      if (hval == '0) begin
        fh_d = HW'(1);
      end else if (32'(hval) > MAX_HEIGHT) begin
        fh_d = HW'(MAX_HEIGHT);
      end else begin
        fh_d = HW'(hval);
      end
    end
  end

  // classify the beat
  assign full_o   = (32'(mid_count_i) + 32'(s1_valid_q)) >= MID_DEPTH;
  assign accept   = push_i && !full_o;
  assign is_pix   = (item_i.kind == KIND_PIXEL);
  assign is_flush = (item_i.kind == KIND_FLUSH) && pend_q;
  assign go       = accept && (is_pix || is_flush);
  assign row_eff  = pend_q ? '0 : row_q;
  assign c        = is_pix ? (pend_q ? '0 : col_q) : flush_q;
  assign col_last = (32'(c) + 32'd1) >= 32'(fw_q);

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    flush_d = flush_q;
    pend_d  = pend_q;
    priority if (restart) begin
      col_d   = '0;
      row_d   = '0;
      flush_d = '0;
      pend_d  = 1'b0;
    end else if (go && is_pix) begin
      flush_d = '0;
      pend_d  = 1'b0;
      if (col_last) begin
        col_d = '0;
        if ((32'(row_eff) + 32'd1) >= 32'(fh_q)) begin
          row_d  = '0;
          pend_d = 1'b1;
        end else begin
          row_d = row_eff + RW'(1);
        end
      end else begin
        col_d = c + AW'(1);
        row_d = row_eff;
      end
    end else if (go) begin
      if (col_last) begin
        flush_d = '0;
        pend_d  = 1'b0;
      end else begin
        flush_d = c + AW'(1);
      end
    end else begin
      pend_d = pend_q;
    end
  end

  // line stores: upper row in the high byte, lower row in the low byte
  mfz_ram #(
    .WIDTH(RAM_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (s1_valid_q && s1_wr_q),
    .waddr_i(s1_addr_q),
    .wdata_i(wdata),
    .re_i   (go),
    .raddr_i(c),
    .rdata_o(rdata)
  );

  // write in flight at the same address is not yet visible in the read
  assign fwd_hit_d = go && s1_valid_q && s1_wr_q && (s1_addr_q == c);

  assign upper_eff = fwd_hit_q ? fwd_data_q[RAM_W-1:PIX_W] : rdata[RAM_W-1:PIX_W];
  assign lower_eff = fwd_hit_q ? fwd_data_q[PIX_W-1:0] : rdata[PIX_W-1:0];
  assign top       = s1_top_ok_q ? upper_eff : '0;
  assign mid       = s1_mid_ok_q ? lower_eff : '0;
  assign wdata     = {lower_eff, s1_pix_q};

  assign col_push_o      = s1_valid_q;
  assign col_o.colsum    = COLSUM_W'(top) + COLSUM_W'(mid) + COLSUM_W'(s1_pix_q);
  assign col_o.first     = s1_first_q;
  assign col_o.last_col  = s1_last_q;
  assign col_o.emit      = s1_emit_q;
  assign col_o.final_row = s1_final_q;

  always_ff @(posedge clk_i) begin
    if (go) begin
      s1_wr_q     <= is_pix;
      s1_addr_q   <= c;
      s1_pix_q    <= is_pix ? item_i.pixel_in : '0;
      s1_first_q  <= (c == '0);
      s1_last_q   <= col_last;
      s1_emit_q   <= is_pix ? (row_eff != '0) : 1'b1;
      s1_final_q  <= !is_pix;
      s1_top_ok_q <= is_pix ? (32'(row_eff) >= 32'd2) : (32'(fh_q) >= 32'd2);
      s1_mid_ok_q <= is_pix ? (row_eff != '0) : 1'b1;
    end
    fwd_data_q <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q       <= WW'(MAX_WIDTH);
      fh_q       <= HW'(MAX_HEIGHT);
      col_q      <= '0;
      row_q      <= '0;
      flush_q    <= '0;
      pend_q     <= 1'b0;
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      fw_q       <= fw_d;
      fh_q       <= fh_d;
      col_q      <= col_d;
      row_q      <= row_d;
      flush_q    <= flush_d;
      pend_q     <= pend_d;
      s1_valid_q <= go;
      fwd_hit_q  <= fwd_hit_d;
    end
  end

endmodule

>>> rtl/core/mfz_back.sv
// back end: column-sum window, divide by nine and result queue
`timescale 1ns / 1ps
module mfz_back import mfz_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     col_empty_i,
  input  mfz_col_t col_i,
  output logic     col_pop_o,
  input  logic     pop_i,
  output mfz_out_t item_o,
  output logic     empty_o
);

  localparam int unsigned RES_CNT_W  = $clog2(RES_DEPTH + 1);
  localparam int unsigned PROD_W     = SUM_W + 13;
  localparam logic [12:0] RECIP_NINE = 13'd7282;
  localparam int unsigned RECIP_SHIFT = 16;

  logic [COLSUM_W-1:0]  p1_q, p2_q;
  logic                 va_q, vb_q, fe_q;
  logic [SUM_W-1:0]     sum_a_q, sum_b_q, sum_a_d, sum_b_d;
  logic [RES_CNT_W-1:0] res_count;
  logic [1:0]           b1_n;
  mfz_out_t             res_a, res_b, data0;

  function automatic logic [PIX_W-1:0] div9(logic [SUM_W-1:0] s);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(s) * PROD_W'(RECIP_NINE);
    return prod[RECIP_SHIFT +: PIX_W];
  endfunction

  assign b1_n      = {1'b0, va_q} + {1'b0, vb_q};
  assign col_pop_o = !col_empty_i &&
                     ((32'(res_count) + 32'(b1_n) + 32'd2) <= RES_DEPTH);

  always_comb begin
    if (col_i.first) begin
      sum_a_d = SUM_W'(col_i.colsum);
      sum_b_d = SUM_W'(col_i.colsum);
    end else begin
      sum_a_d = SUM_W'(p1_q) + SUM_W'(p2_q) + SUM_W'(col_i.colsum);
      sum_b_d = SUM_W'(p2_q) + SUM_W'(col_i.colsum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (col_pop_o) begin
      p1_q    <= col_i.first ? '0 : p2_q;
      p2_q    <= col_i.colsum;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      fe_q    <= col_i.final_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= col_pop_o && col_i.emit && !col_i.first;
      vb_q <= col_pop_o && col_i.emit && col_i.last_col;
    end
  end

  assign res_a.pixel_out = div9(sum_a_q);
  assign res_a.frame_end = 1'b0;
  assign res_a.last      = !vb_q;
  assign res_b.pixel_out = div9(sum_b_q);
  assign res_b.frame_end = fe_q;
  assign res_b.last      = 1'b1;
  assign data0           = va_q ? res_a : res_b;

  mfz_fifo #(
    .T    (mfz_out_t),
    .DEPTH(RES_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push0_i(va_q || vb_q),
    .push1_i(va_q && vb_q),
    .data0_i(data0),
    .data1_i(res_b),
    .pop_i  (pop_i),
    .data_o (item_o),
    .empty_o(empty_o),
    .count_o(res_count)
  );

endmodule

>>> rtl/core/mean_filter_3x3_zero_pad.sv
// 3x3 box filter, zero padded; column sums pass through a queue to the window and divider
// throughput: one input beat per clock while full is low, set by the line ram (one read, one write)
// an emitting row end gives two results (one at width one); the result queue absorbs the extra beat
// reset clears counters, queues and pipeline valids, frame size returns to max
// the line stores are not cleared, there is no clearing pass
`timescale 1ns / 1ps
module mean_filter_3x3_zero_pad import mfz_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  push,
  output logic                  full,
  input  mfz_in_t               item_i,
  output logic                  empty,
  input  logic                  pop,
  output mfz_out_t              item_o
);

  logic                 col_push, col_pop, col_empty;
  mfz_col_t             col_wr, col_rd;
  logic [MID_CNT_W-1:0] mid_count;

  assign cfg_ready_o = 1'b1;

  mfz_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push_i     (push),
    .item_i     (item_i),
    .full_o     (full),
    .mid_count_i(mid_count),
    .col_push_o (col_push),
    .col_o      (col_wr)
  );

  mfz_fifo #(
    .T    (mfz_col_t),
    .DEPTH(MID_DEPTH)
  ) u_col_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push0_i(col_push),
    .push1_i(1'b0),
    .data0_i(col_wr),
    .data1_i('0),
    .pop_i  (col_pop),
    .data_o (col_rd),
    .empty_o(col_empty),
    .count_o(mid_count)
  );

  mfz_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .col_empty_i(col_empty),
    .col_i      (col_rd),
    .col_pop_o  (col_pop),
    .pop_i      (pop),
    .item_o     (item_o),
    .empty_o    (empty)
  );

endmodule

>>> rtl/core/mfz_checker.sv
// port-level checks of the 3x3 mean filter and their bind
`timescale 1ns / 1ps
`include "mean_filter_3x3_zero_pad_macros.svh"
module mfz_port_checker import mfz_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     empty,
  input logic     pop,
  input mfz_out_t item_o
);

  logic beat_fe, pair_pop, stall;

  assign beat_fe  = !empty && item_o.frame_end;
  assign pair_pop = !empty && pop && !item_o.last;
  assign stall    = !empty && !pop;

  `MFZ_ASSERT(a_frame_end_is_last, clk_i, rst_ni, beat_fe |-> item_o.last, "frame end not last")
  `MFZ_ASSERT_NEXT(a_pair_follows, clk_i, rst_ni, pair_pop, !empty, "pair result missing")
  `MFZ_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, stall, !empty && $stable(item_o), "stall broken")

endmodule

bind mean_filter_3x3_zero_pad mfz_port_checker u_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .empty (empty),
  .pop   (pop),
  .item_o(item_o)
);
